FILE: src/tld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_pkg
// Shared types, constants and codes of the terminal line discipline.
// ----------------------------------------------------------------------------
package tld_pkg;

  localparam int LINE_STORE_DEPTH = 256;
  localparam int POS_W            = $clog2(LINE_STORE_DEPTH + 1);
  localparam int ADDR_W           = $clog2(LINE_STORE_DEPTH);
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_TX           = 4;
  localparam int TXCNT_W          = $clog2(MAX_TX + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // mode_flags bit positions
  localparam int MB_IXON   = 0;
  localparam int MB_ICRNL  = 1;
  localparam int MB_IGNCR  = 2;
  localparam int MB_ISIG   = 3;
  localparam int MB_ICANON = 4;
  localparam int MB_ECHO   = 5;
  localparam int MB_OPOST  = 6;
  localparam int MB_ONLCR  = 7;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_INTR   = 3'd1,
    REG_QUIT   = 3'd2,
    REG_EOF    = 3'd3,
    REG_START  = 3'd4,
    REG_STOP   = 3'd5,
    REG_FGND   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_RECV = 2'd0,
    OP_READ = 2'd1,
    OP_SEND = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DROP     = 2'd1,
    ST_NOTREADY = 2'd2,
    ST_STOPPED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SIG_NONE = 2'd0,
    SIG_INT  = 2'd1,
    SIG_QUIT = 2'd2
  } sig_t;

  // outcome of one item, handed from front to back
  typedef struct packed {
    status_t                   status;
    logic                      rvalid;
    logic [7:0]                rbyte;
    logic                      eol;
    logic                      eof;
    sig_t                      sig;
    logic                      wake;
    logic                      readable;
    logic [TXCNT_W-1:0]        tx_cnt;
    logic [MAX_TX-1:0][7:0]    tx;
  } desc_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: src/tld_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/tld_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_front
// Accepts items, holds configuration and line state, classifies each item
// and pushes its outcome to the result queue.
// ----------------------------------------------------------------------------
module tld_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        operation,
  input  logic [7:0]        data_byte,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [7:0]        wr_data,
  input  logic              q_ready,
  output logic              push,
  output tld_pkg::desc_t    push_desc,
  output tld_pkg::mem_req_t mem_req,
  input  logic [7:0]        mem_q
);
  import tld_pkg::*;

  logic [7:0] mode_flags, interrupt_char, quit_char, end_of_file_char;
  logic [7:0] start_char, stop_char;
  logic       foreground_valid;

  logic [POS_W-1:0] write_position, write_position_next;
  logic [POS_W-1:0] read_position, read_position_next;
  logic [POS_W-1:0] pending_terminators, pending_terminators_next;
  logic             output_stopped, output_stopped_next;
  logic             rd_wait;

  logic       accept, crnl, rd_ok, term_in, term_out, not_empty;
  logic [7:0] c2;
  desc_t      d;

  assign item_stall = rd_wait || !q_ready;
  assign accept     = item_valid && !item_stall;
  assign crnl       = mode_flags[MB_OPOST] && mode_flags[MB_ONLCR];
  assign not_empty  = read_position < write_position;
  assign rd_ok      = (mode_flags[MB_ICANON] ? (pending_terminators != '0) : not_empty)
                      && not_empty && (read_position < POS_W'(LINE_STORE_DEPTH));
  assign c2         = (data_byte == CH_CR && mode_flags[MB_ICRNL]) ? CH_NL : data_byte;
  assign term_in    = (c2 == CH_NL) || (c2 == end_of_file_char);
  assign term_out   = (mem_q == CH_NL) || (mem_q == end_of_file_char);
  assign push_desc  = d;

  always_comb begin
    write_position_next      = write_position;
    read_position_next       = read_position;
    pending_terminators_next = pending_terminators;
    output_stopped_next      = output_stopped;
    push                     = 1'b0;
    mem_req                  = '0;
    d                        = '0;
    if (rd_wait) begin
      // popped byte is back from the line store
      push               = 1'b1;
      read_position_next = read_position + 1'b1;
      if (term_out && pending_terminators != '0) begin
        pending_terminators_next = pending_terminators - 1'b1;
      end
      if (mem_q == end_of_file_char) begin
        d.eof = 1'b1;
      end else begin
        d.rvalid = 1'b1;
        d.rbyte  = mem_q;
        d.eol    = mode_flags[MB_ICANON] && (mem_q == CH_NL);
      end
      if (read_position_next >= write_position) begin
        read_position_next       = '0;
        write_position_next      = '0;
        pending_terminators_next = '0;
      end
    end else if (accept) begin
      push = !(operation == OP_READ && rd_ok);
      case (operation)
        OP_RECV: begin
          if (mode_flags[MB_IXON] && data_byte == stop_char) begin
            output_stopped_next = 1'b1;
          end else if (mode_flags[MB_IXON] && data_byte == start_char) begin
            output_stopped_next = 1'b0;
          end else if (data_byte == CH_NUL) begin
            d.status = ST_DROP;
          end else if (mode_flags[MB_ISIG] &&
                       (data_byte == interrupt_char || data_byte == quit_char)) begin
            if (foreground_valid) begin
              d.sig = (data_byte == interrupt_char) ? SIG_INT : SIG_QUIT;
              if (mode_flags[MB_ECHO]) begin
                d.tx[0]  = CH_CARET;
                d.tx[1]  = (data_byte == interrupt_char) ? CH_C : CH_BSLASH;
                d.tx[2]  = crnl ? CH_CR : CH_NL;
                d.tx[3]  = CH_NL;
                d.tx_cnt = crnl ? TXCNT_W'(4) : TXCNT_W'(3);
              end
              write_position_next      = '0;
              read_position_next       = '0;
              pending_terminators_next = '0;
            end else begin
              d.status = ST_DROP;
            end
          end else if (data_byte == CH_CR && mode_flags[MB_IGNCR]) begin
            d.status = ST_DROP;
          end else if (write_position >= POS_W'(LINE_STORE_DEPTH)) begin
            d.status = ST_DROP;
          end else begin
            mem_req.we          = 1'b1;
            mem_req.waddr       = write_position[ADDR_W-1:0];
            mem_req.wdata       = c2;
            write_position_next = write_position + 1'b1;
            if (term_in && pending_terminators < POS_W'(LINE_STORE_DEPTH)) begin
              pending_terminators_next = pending_terminators + 1'b1;
            end
            if (mode_flags[MB_ECHO]) begin
              if (crnl && c2 == CH_NL) begin
                d.tx[0]  = CH_CR;
                d.tx[1]  = CH_NL;
                d.tx_cnt = TXCNT_W'(2);
              end else begin
                d.tx[0]  = c2;
                d.tx_cnt = TXCNT_W'(1);
              end
            end
            d.wake = !mode_flags[MB_ICANON] || term_in;
          end
        end
        OP_READ: begin
          if (!rd_ok) begin
            d.status = ST_NOTREADY;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = read_position[ADDR_W-1:0];
          end
        end
        OP_SEND: begin
          if (output_stopped) begin
            d.status = ST_STOPPED;
          end else if (crnl && data_byte == CH_NL) begin
            d.tx[0]  = CH_CR;
            d.tx[1]  = CH_NL;
            d.tx_cnt = TXCNT_W'(2);
          end else begin
            d.tx[0]  = data_byte;
            d.tx_cnt = TXCNT_W'(1);
          end
        end
        default: begin
          d.status = ST_DROP;
        end
      endcase
    end
    d.readable = mode_flags[MB_ICANON] ? (pending_terminators_next != '0)
                                       : (read_position_next < write_position_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags          <= 8'd251;
      interrupt_char      <= 8'd3;
      quit_char           <= 8'd28;
      end_of_file_char    <= 8'd4;
      start_char          <= 8'd17;
      stop_char           <= 8'd19;
      foreground_valid    <= 1'b1;
      write_position      <= '0;
      read_position       <= '0;
      pending_terminators <= '0;
      output_stopped      <= 1'b0;
      rd_wait             <= 1'b0;
    end else begin
      write_position      <= write_position_next;
      read_position       <= read_position_next;
      pending_terminators <= pending_terminators_next;
      output_stopped      <= output_stopped_next;
      rd_wait             <= mem_req.re;
      if (wr_en) begin
        case (wr_index)
          REG_MODE:  mode_flags       <= wr_data;
          REG_INTR:  interrupt_char   <= wr_data;
          REG_QUIT:  quit_char        <= wr_data;
          REG_EOF:   end_of_file_char <= wr_data;
          REG_START: start_char       <= wr_data;
          REG_STOP:  stop_char        <= wr_data;
          REG_FGND:  foreground_valid <= wr_data[0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: src/tld_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_queue
// Short queue of item outcomes between the front and the back.
// ----------------------------------------------------------------------------
module tld_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tld_pkg::desc_t push_desc,
  output logic           q_ready,
  input  logic           pop,
  output logic           q_valid,
  output tld_pkg::desc_t head
);
  import tld_pkg::*;

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign q_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign head    = entries[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/tld_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_back
// Expands each item outcome into its results, one per cycle while result_stall
// is low, through an output register.
// ----------------------------------------------------------------------------
module tld_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  tld_pkg::desc_t head,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_stall,
  output logic [1:0]     status,
  output logic           tx_valid,
  output logic [7:0]     tx_byte,
  output logic           read_valid,
  output logic [7:0]     read_byte,
  output logic           end_of_line,
  output logic           end_of_file,
  output logic [1:0]     signal_code,
  output logic           wake,
  output logic           readable,
  output logic           last
);
  import tld_pkg::*;

  desc_t              cur;
  logic               cur_valid;
  logic [1:0]         idx;
  logic [TXCNT_W-1:0] n_res, idx_w;
  logic               out_free, load, is_last, cur_done, idx_tx;

  assign out_free = !result_valid || !result_stall;
  assign load     = cur_valid && out_free;
  assign n_res    = (cur.tx_cnt == '0) ? TXCNT_W'(1) : cur.tx_cnt;
  assign idx_w    = TXCNT_W'(idx);
  assign is_last  = (idx_w + 1'b1) == n_res;
  assign idx_tx   = idx_w < cur.tx_cnt;
  assign cur_done = load && is_last;
  assign pop      = q_valid && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (load) begin
      status      <= cur.status;
      tx_valid    <= idx_tx;
      tx_byte     <= idx_tx ? cur.tx[idx] : 8'd0;
      read_valid  <= cur.rvalid;
      read_byte   <= cur.rbyte;
      end_of_line <= cur.eol;
      end_of_file <= cur.eof;
      signal_code <= (idx == 2'd0) ? cur.sig : SIG_NONE;
      wake        <= is_last && cur.wake;
      readable    <= cur.readable;
      last        <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
      end else if (load) begin
        idx <= idx + 1'b1;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/terminal_line_discipline.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_discipline
// Terminal line discipline: receive processing with line store, host reads
// and transmit output processing.
// ----------------------------------------------------------------------------
// The front takes one item per cycle while item_stall is low. Received and
// transmit bytes and reads that find nothing ready add no stall; a read that
// pops a byte stalls it until the byte is back from the registered read of
// the line store. The back sends one result per cycle while result_stall is
// low: one result for most items, two for a newline that is echoed or sent
// as CR NL, and up to four for an interrupt or quit echo. A four-entry queue
// between the two lets items keep arriving while results wait on the output.
// The line store needs no clearing, so items are taken right after reset.
// ----------------------------------------------------------------------------
module terminal_line_discipline (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] operation,
  input  logic [7:0] data_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] status,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       read_valid,
  output logic [7:0] read_byte,
  output logic       end_of_line,
  output logic       end_of_file,
  output logic [1:0] signal_code,
  output logic       wake,
  output logic       readable,
  output logic       last,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [7:0] wr_data
);
  import tld_pkg::*;

  logic     push, q_ready, q_valid, pop;
  desc_t    push_desc, head;
  mem_req_t mem_req;
  logic [7:0] mem_q;

  tld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .operation  (operation),
    .data_byte  (data_byte),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .q_ready    (q_ready),
    .push       (push),
    .push_desc  (push_desc),
    .mem_req    (mem_req),
    .mem_q      (mem_q)
  );

  tld_ram #(
    .WIDTH (8),
    .DEPTH (LINE_STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_q)
  );

  tld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  tld_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .read_valid   (read_valid),
    .read_byte    (read_byte),
    .end_of_line  (end_of_line),
    .end_of_file  (end_of_file),
    .signal_code  (signal_code),
    .wake         (wake),
    .readable     (readable),
    .last         (last)
  );

endmodule

FILE: src/tld_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_checker
// Port-level checks on the terminal line discipline, bound to the top level.
// ----------------------------------------------------------------------------
module tld_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [1:0] status,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       read_valid,
  input logic [7:0] read_byte,
  input logic [1:0] signal_code,
  input logic       wake,
  input logic       last
);
  import tld_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // unused byte fields read as zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (tx_valid || tx_byte == 8'd0) && (read_valid || read_byte == 8'd0))
    else $error("byte field not zero without its valid");

  // wake only rides on the final result of an item
  a_wake: assert property (@(posedge clk) disable iff (rst)
    result_valid && wake |-> last)
    else $error("wake on a non-final result");

  // a signal is raised only by a received byte that was consumed cleanly
  a_sig: assert property (@(posedge clk) disable iff (rst)
    result_valid && signal_code != SIG_NONE |-> status == ST_OK && !read_valid)
    else $error("signal with bad status or read data");

  // the signal code sits on the first result of an item only
  a_sig_first: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !last |=> !result_valid || signal_code == SIG_NONE)
    else $error("signal code on a later result");

endmodule

bind terminal_line_discipline tld_checker u_tld_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .tx_valid     (tx_valid),
  .tx_byte      (tx_byte),
  .read_valid   (read_valid),
  .read_byte    (read_byte),
  .signal_code  (signal_code),
  .wake         (wake),
  .last         (last)
);
